[design/alc_pkg.sv]
// shared types for the array list with cursor block
// request and status codes, datapath command and status structs; no dependencies
package alc_pkg;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_FIRST  = 2'd1,
        REQ_NEXT   = 2'd2,
        REQ_REMOVE = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_END   = 2'd2,
        ST_NOCUR = 2'd3
    } t_status;

    localparam int DATA_W  = 32;
    localparam int COUNT_W = 8;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_CAPTURE,
        DP_INSERT,
        DP_FIRST,
        DP_NEXT,
        DP_REMOVE,
        DP_FAIL,
        DP_TAKE,
        DP_SHIFT_RD,
        DP_SHIFT_WR,
        DP_FINISH,
        DP_LOAD
    } t_dp_op;

    typedef struct packed {
        t_dp_op  op;
        t_status status;
    } t_dp_cmd;

    typedef struct packed {
        t_req req;
        logic full;
        logic empty;
        logic at_end;
        logic no_cur;
        logic shift_done;
    } t_dp_stat;

endpackage

[design/alc_req_if.sv]
// request channel of the array list block
// depends on alc_pkg
interface alc_req_if;
    import alc_pkg::*;

    logic                valid;
    logic                ready;
    t_req                req_type;
    logic [DATA_W-1:0]   data_in;

    modport source (output valid, output req_type, output data_in, input ready);
    modport sink   (input valid, input req_type, input data_in, output ready);
endinterface

[design/alc_rsp_if.sv]
// result channel of the array list block
// depends on alc_pkg
interface alc_rsp_if;
    import alc_pkg::*;

    logic                valid;
    logic                ready;
    t_status             status;
    logic [DATA_W-1:0]   data_out;
    logic [COUNT_W-1:0]  item_count;

    modport source (output valid, output status, output data_out, output item_count,
                    input ready);
    modport sink   (input valid, input status, input data_out, input item_count,
                    output ready);
endinterface

[design/alc_ram.sv]
// generic simple dual port ram, one write and one registered read per cycle
// no dependencies
module alc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[design/alc_ctrl.sv]
// request sequencer of the array list block
// depends on alc_pkg; drives the datapath through t_dp_cmd
module alc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  alc_pkg::t_dp_stat i_stat,
    output alc_pkg::t_dp_cmd  o_cmd
);
    import alc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RD_WAIT,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_DONE
    } t_state;

    t_state  r_state, n_state;
    logic    r_out_valid, n_out_valid;
    t_dp_cmd cmd;
    logic    out_free;

    // output register is free when empty or being taken this cycle
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        cmd.op      = DP_NOP;
        cmd.status  = ST_OK;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.op  = DP_CAPTURE;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                case (i_stat.req)
                    REQ_INSERT: begin
                        if (i_stat.full) begin
                            cmd.op     = DP_FAIL;
                            cmd.status = ST_FULL;
                        end else begin
                            cmd.op = DP_INSERT;
                        end
                    end
                    REQ_FIRST: begin
                        if (i_stat.empty) begin
                            cmd.op     = DP_FAIL;
                            cmd.status = ST_END;
                        end else begin
                            cmd.op  = DP_FIRST;
                            n_state = S_RD_WAIT;
                        end
                    end
                    REQ_NEXT: begin
                        if (i_stat.at_end) begin
                            cmd.op     = DP_FAIL;
                            cmd.status = ST_END;
                        end else begin
                            cmd.op  = DP_NEXT;
                            n_state = S_RD_WAIT;
                        end
                    end
                    REQ_REMOVE: begin
                        if (i_stat.no_cur) begin
                            cmd.op     = DP_FAIL;
                            cmd.status = ST_NOCUR;
                        end else begin
                            cmd.op  = DP_REMOVE;
                            n_state = S_RD_WAIT;
                        end
                    end
                    default: begin
                        cmd.op     = DP_FAIL;
                        cmd.status = ST_NOCUR;
                    end
                endcase
            end
            S_RD_WAIT: begin
                cmd.op  = DP_TAKE;
                n_state = (i_stat.req == REQ_REMOVE) ? S_SHIFT_RD : S_DONE;
            end
            S_SHIFT_RD: begin
                if (i_stat.shift_done) begin
                    cmd.op  = DP_FINISH;
                    n_state = S_DONE;
                end else begin
                    cmd.op  = DP_SHIFT_RD;
                    n_state = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                cmd.op  = DP_SHIFT_WR;
                n_state = S_SHIFT_RD;
            end
            S_DONE: begin
                if (out_free) begin
                    cmd.op      = DP_LOAD;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) && !r_out_valid |=> r_out_valid && (r_state == S_IDLE))
        else $error("finished request not moved into the output register");
endmodule

[design/alc_dp.sv]
// datapath of the array list block: entry ram, count, cursor, shift index, result registers
// depends on alc_pkg and alc_ram
module alc_dp #(
    parameter int CAPACITY  = 128,
    parameter int WORD_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  alc_pkg::t_dp_cmd              i_cmd,
    output alc_pkg::t_dp_stat             o_stat,
    input  alc_pkg::t_req                 i_req_type,
    input  logic [alc_pkg::DATA_W-1:0]    i_data_in,
    output alc_pkg::t_status              o_status,
    output logic [alc_pkg::DATA_W-1:0]    o_data_out,
    output logic [alc_pkg::COUNT_W-1:0]   o_item_count
);
    import alc_pkg::*;

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    // cursor is kept plus one so that "before first" is zero
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     r_cur_p1;
    logic [CNT_W-1:0]     r_idx;
    t_req                 r_req;
    logic [WORD_BITS-1:0] r_word;
    t_status              r_res_status;
    logic [DATA_W-1:0]    r_res_data;
    t_status              r_out_status;
    logic [DATA_W-1:0]    r_out_data;
    logic [COUNT_W-1:0]   r_out_count;

    logic [CNT_W-1:0]     idx_p1;
    logic [CNT_W-1:0]     cur_m1;
    logic                 we;
    logic [ADDR_W-1:0]    waddr;
    logic [WORD_BITS-1:0] wdata;
    logic                 re;
    logic [ADDR_W-1:0]    raddr;
    logic [WORD_BITS-1:0] rdata;

    assign idx_p1 = r_idx + CNT_W'(1);
    assign cur_m1 = r_cur_p1 - CNT_W'(1);

    always_comb begin
        we    = 1'b0;
        waddr = r_idx[ADDR_W-1:0];
        wdata = rdata;
        re    = 1'b0;
        raddr = idx_p1[ADDR_W-1:0];
        case (i_cmd.op)
            DP_INSERT: begin
                we    = 1'b1;
                waddr = r_count[ADDR_W-1:0];
                wdata = r_word;
            end
            DP_FIRST: begin
                re    = 1'b1;
                raddr = '0;
            end
            DP_NEXT: begin
                re    = 1'b1;
                raddr = r_cur_p1[ADDR_W-1:0];
            end
            DP_REMOVE: begin
                re    = 1'b1;
                raddr = cur_m1[ADDR_W-1:0];
            end
            DP_SHIFT_RD: begin
                re = 1'b1;
            end
            DP_SHIFT_WR: begin
                we = 1'b1;
            end
            default: begin
                we = 1'b0;
                re = 1'b0;
            end
        endcase
    end

    alc_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // count and cursor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_cur_p1 <= '0;
        end else begin
            case (i_cmd.op)
                DP_INSERT: r_count  <= r_count + CNT_W'(1);
                DP_FIRST:  r_cur_p1 <= CNT_W'(1);
                DP_NEXT:   r_cur_p1 <= r_cur_p1 + CNT_W'(1);
                DP_FINISH: begin
                    r_count  <= r_count - CNT_W'(1);
                    r_cur_p1 <= cur_m1;
                end
                default: begin
                    r_count  <= r_count;
                    r_cur_p1 <= r_cur_p1;
                end
            endcase
        end
    end

    // request, shift index and result payload
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_CAPTURE: begin
                r_req  <= i_req_type;
                r_word <= WORD_BITS'(i_data_in);
            end
            DP_INSERT: begin
                r_res_status <= ST_OK;
                r_res_data   <= '0;
            end
            DP_FIRST, DP_NEXT: begin
                r_res_status <= ST_OK;
            end
            DP_REMOVE: begin
                r_res_status <= ST_OK;
                r_idx        <= cur_m1;
            end
            DP_FAIL: begin
                r_res_status <= i_cmd.status;
                r_res_data   <= '0;
            end
            DP_TAKE: begin
                r_res_data <= DATA_W'(rdata);
            end
            DP_SHIFT_WR: begin
                r_idx <= idx_p1;
            end
            DP_LOAD: begin
                r_out_status <= r_res_status;
                r_out_data   <= r_res_data;
                r_out_count  <= COUNT_W'(r_count);
            end
            default: begin
                r_idx <= r_idx;
            end
        endcase
    end

    assign o_stat.req        = r_req;
    assign o_stat.full       = (r_count == CNT_W'(CAPACITY));
    assign o_stat.empty      = (r_count == '0);
    assign o_stat.at_end     = (r_cur_p1 >= r_count);
    assign o_stat.no_cur     = (r_cur_p1 == '0) || (r_cur_p1 > r_count);
    assign o_stat.shift_done = (idx_p1 >= r_count);

    assign o_status     = r_out_status;
    assign o_data_out   = r_out_data;
    assign o_item_count = r_out_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_cursor_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_p1 <= r_count)
        else $error("cursor past the last entry");

    a_shift_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == DP_SHIFT_WR) |-> (idx_p1 < r_count))
        else $error("compaction writes outside the stored entries");
endmodule

[design/array_list_with_cursor_core.sv]
// top level of the array list with cursor block
// depends on alc_pkg, alc_req_if, alc_rsp_if, alc_ctrl, alc_dp, alc_ram
//
// Packed list of up to CAPACITY words with a cursor, one result per request. Requests are
// handled one at a time; the entries live in a single ram with one write and one registered
// read port. From acceptance to the result being presented, insert and every failing request
// pass the execute and done states, first and next also wait for the registered ram read, and
// a remove additionally moves each later entry down by a read and a write of the ram. A new
// request is taken once the previous one has reached the output register, even while that
// result waits to be taken.
module array_list_with_cursor_core #(
    parameter int CAPACITY  = 128,
    parameter int WORD_BITS = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    alc_req_if.sink   i_req,
    alc_rsp_if.source o_rsp
);
    import alc_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;
    logic     in_ready;
    logic     out_valid;

    alc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    alc_dp #(
        .CAPACITY  (CAPACITY),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_stat       (dp_stat),
        .i_req_type   (i_req.req_type),
        .i_data_in    (i_req.data_in),
        .o_status     (o_rsp.status),
        .o_data_out   (o_rsp.data_out),
        .o_item_count (o_rsp.item_count)
    );

    assign i_req.ready = in_ready;
    assign o_rsp.valid = out_valid;
endmodule
